// ===== hdl/fspa_pkg.sv =====
// fixed slot pool allocator: shared types and constants
// used by every module of the block but fspa_ram; depends on nothing
`default_nettype none

package fspa_pkg;

    // data widths of the configuration registers and item fields
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 13;
    localparam int COUNT_W     = 11;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // default pool depth
    localparam int MAX_SLOTS_DEFAULT = 1024;

    // register reset values
    localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

    // register indexes (word address)
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_MISALIGN = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4,
        ST_NULL     = 3'd5
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    latch_in;
        logic    alloc_take;
        logic    mul_en;
        logic    add_en;
        logic    div_start;
        logic    free_commit;
        logic    out_load;
        status_t out_status;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic mode_free;
        logic addr_zero;
        logic addr_below;
        logic pool_empty;
        logic div_done;
        logic rem_nonzero;
        logic idx_over;
        logic ring_full;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fspa_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fspa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/fspa_div.sv =====
// restoring divider, one quotient bit per cycle, 32 steps
// depends on fspa_pkg for the operand widths
`default_nettype none

module fspa_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fspa_pkg::ADDR_W-1:0] dividend,
    input  wire logic [fspa_pkg::SIZE_W-1:0] divisor,
    output logic                             done,
    output logic      [fspa_pkg::ADDR_W-1:0] quotient,
    output logic      [fspa_pkg::SIZE_W-1:0] remainder
);

    import fspa_pkg::*;

    localparam int STEPS = ADDR_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [ADDR_W-1:0] quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SIZE_W:0]   trial;
    logic              ge;
    logic [SIZE_W-1:0] rem_next;

    // one trial subtraction per step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ADDR_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? SIZE_W'(trial - {1'b0, dvs_reg}) : trial[SIZE_W-1:0];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/fspa_dpath.sv =====
// datapath: request registers, free ring pointers, ring memory, divider,
// address multiply-add and the result register; uses fspa_pkg, fspa_ram, fspa_div
`default_nettype none

module fspa_dpath #(
    parameter int MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic [fspa_pkg::ADDR_W-1:0]  base_address,
    input  wire logic [fspa_pkg::SIZE_W-1:0]  slot_size,
    input  wire logic                         refill,
    input  wire logic [fspa_pkg::COUNT_W-1:0] refill_count,
    // request payload
    input  wire logic                         mode,
    input  wire logic [fspa_pkg::ADDR_W-1:0]  address,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [2:0]                   status,
    output logic      [fspa_pkg::ADDR_W-1:0]  slot_address,
    // controller link
    input  wire fspa_pkg::dp_cmd_t            cmd,
    output fspa_pkg::dp_stat_t                stat
);

    import fspa_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    // request and ring state
    logic              mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     free_count_reg;
    logic [CW-1:0]     eff_count_reg;
    logic [AW-1:0]     fill_base_reg;
    logic [CW-1:0]     written_reg;
    logic [AW-1:0]     rd_pos_reg;
    logic [ADDR_W-1:0] mul_reg;
    logic [ADDR_W-1:0] res_addr_reg;

    // result register
    logic              out_valid_reg;
    status_t           status_reg;
    logic [ADDR_W-1:0] slot_addr_reg;

    logic [SIZE_W-1:0] size_eff;
    logic [ADDR_W-1:0] diff;
    logic [CW-1:0]     refill_eff;
    logic [AW-1:0]     tail;
    logic [ADDR_W-1:0] tail_sum;
    logic [CW-1:0]     ring_dist;
    logic              entry_written;
    logic [AW-1:0]     ring_data;
    logic [AW-1:0]     idx_sel;
    logic              div_done;
    logic [ADDR_W-1:0] quotient;
    logic [SIZE_W-1:0] remainder;

    // effective size, offset from base and clamped refill count
    always_comb
    begin
        size_eff   = (slot_size == '0) ? SIZE_W'(1) : slot_size;
        diff       = addr_reg - base_address;
        refill_eff = (ADDR_W'(refill_count) > ADDR_W'(MAX_SLOTS))
                     ? CW'(MAX_SLOTS) : CW'(refill_count);
    end

    // ring tail position, wrapped at the pool depth
    always_comb
    begin
        tail_sum = ADDR_W'(head_reg) + ADDR_W'(free_count_reg);
        tail     = (tail_sum >= ADDR_W'(MAX_SLOTS))
                   ? AW'(tail_sum - ADDR_W'(MAX_SLOTS)) : AW'(tail_sum);
    end

    // an entry holds a freed index only if it lies in the region written
    // since the last refill; otherwise it still holds its own position
    always_comb
    begin
        if (rd_pos_reg >= fill_base_reg)
        begin
            ring_dist = CW'(ADDR_W'(rd_pos_reg) - ADDR_W'(fill_base_reg));
        end
        else
        begin
            ring_dist = CW'(ADDR_W'(rd_pos_reg) + ADDR_W'(MAX_SLOTS)
                            - ADDR_W'(fill_base_reg));
        end
        entry_written = (ring_dist < written_reg);
        idx_sel       = entry_written ? ring_data : rd_pos_reg;
    end

    fspa_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_SLOTS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.free_commit),
        .wr_addr (tail),
        .wr_data (AW'(quotient)),
        .rd_en   (cmd.alloc_take),
        .rd_addr (head_reg),
        .rd_data (ring_data)
    );

    fspa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (diff),
        .divisor   (size_eff),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // ring pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            free_count_reg <= '0;
            eff_count_reg  <= '0;
            fill_base_reg  <= '0;
            written_reg    <= '0;
        end
        else if (refill)
        begin
            head_reg       <= '0;
            free_count_reg <= refill_eff;
            eff_count_reg  <= refill_eff;
            fill_base_reg  <= (refill_eff == CW'(MAX_SLOTS)) ? '0 : AW'(refill_eff);
            written_reg    <= '0;
        end
        else if (cmd.alloc_take)
        begin
            head_reg       <= (head_reg == AW'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;
            free_count_reg <= free_count_reg - 1'b1;
        end
        else if (cmd.free_commit)
        begin
            free_count_reg <= free_count_reg + 1'b1;
            if (written_reg != CW'(MAX_SLOTS))
            begin
                written_reg <= written_reg + 1'b1;
            end
        end
    end

    // request registers and address arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg     <= mode;
            addr_reg     <= address;
            res_addr_reg <= '0;
        end
        else if (cmd.add_en)
        begin
            res_addr_reg <= base_address + mul_reg;
        end
        if (cmd.alloc_take)
        begin
            rd_pos_reg <= head_reg;
        end
        if (cmd.mul_en)
        begin
            mul_reg <= ADDR_W'(idx_sel) * ADDR_W'(size_eff);
        end
    end

    // result register, holds until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg    <= cmd.out_status;
            slot_addr_reg <= res_addr_reg;
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.mode_free   = (mode_reg == MODE_FREE);
        stat.addr_zero   = (addr_reg == '0);
        stat.addr_below  = (addr_reg < base_address);
        stat.pool_empty  = (free_count_reg == '0);
        stat.div_done    = div_done;
        stat.rem_nonzero = (remainder != '0);
        stat.idx_over    = (quotient >= ADDR_W'(eff_count_reg));
        stat.ring_full   = (free_count_reg >= eff_count_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_address = slot_addr_reg;

endmodule

`default_nettype wire

// ===== hdl/fspa_ctrl.sv =====
// controller state machine: sequences allocate and free requests
// depends on fspa_pkg for the command and status structs
`default_nettype none

module fspa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire fspa_pkg::dp_stat_t stat,
    output fspa_pkg::dp_cmd_t       cmd
);

    import fspa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_CHECK,
        S_FIN
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    ready_reg;
    logic    ready_next;
    status_t res_status_reg;
    status_t res_status_next;
    logic    accept;

    assign accept = in_valid && ready_reg;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        ready_next      = ready_reg;
        res_status_next = res_status_reg;
        cmd             = '0;
        cmd.out_status  = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_in = 1'b1;
                    ready_next   = 1'b0;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.mode_free)
                begin
                    if (stat.pool_empty)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.alloc_take = 1'b1;
                        state_next     = S_MUL;
                    end
                end
                else if (stat.addr_zero)
                begin
                    res_status_next = ST_NULL;
                    state_next      = S_FIN;
                end
                else if (stat.addr_below)
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_en      = 1'b1;
                res_status_next = ST_OK;
                state_next      = S_FIN;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.rem_nonzero)
                begin
                    res_status_next = ST_MISALIGN;
                end
                else if (stat.idx_over)
                begin
                    res_status_next = ST_RANGE;
                end
                else if (stat.ring_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    cmd.free_commit = 1'b1;
                    res_status_next = ST_OK;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                ready_next = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ready_reg      <= 1'b1;
            res_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            ready_reg      <= ready_next;
            res_status_reg <= res_status_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

// ===== hdl/fixed_slot_pool_allocator.sv =====
// Fixed-size slot pool allocator with a first-in first-out free list.
//
// Request channel (in_valid / in_ready, fields mode and address): mode 0
// allocates the oldest free slot, mode 1 returns the slot at address.
// Result channel (out_valid / out_ready, fields status and slot_address):
// one result per request, in request order, held in an output register.
// Configuration: APB-style port, base_address at 0x0, slot_size at 0x4,
// slot_count at 0x8; writing slot_count refills the free list in order.
// An allocate result is registered after the ring memory read, the
// multiply and the add. A free result waits for the 32-step restoring
// divider that turns the offset from the base into a slot index and
// remainder. One request is in flight at a time; the next transfer is
// taken in the cycle after the result is registered, even while that
// result still waits for out_ready.
// Reset: empty pool (slot_count 0), slot_size 8, base 0, no result pending.
// A stalled receiver holds the result; the block then stops taking
// requests once a second result is ready.
// Depends on fspa_pkg, fspa_ctrl, fspa_dpath, fspa_div and fspa_ram.
`default_nettype none

module fixed_slot_pool_allocator #(
    parameter int MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fspa_pkg::APB_AW-1:0] paddr,
    input  wire logic [fspa_pkg::APB_DW-1:0] pwdata,
    output logic      [fspa_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    // request channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [fspa_pkg::ADDR_W-1:0] address,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [2:0]                  status,
    output logic      [fspa_pkg::ADDR_W-1:0] slot_address
);

    import fspa_pkg::*;

    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [1:0]         reg_idx;
    logic               wr_strobe;
    logic               refill;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign wr_strobe = psel && penable && pwrite;
    assign refill    = wr_strobe && (reg_idx == REG_COUNT);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            size_reg  <= SIZE_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (wr_strobe)
        begin
            case (reg_idx)
                REG_BASE:  base_reg  <= pwdata[ADDR_W-1:0];
                REG_SIZE:  size_reg  <= pwdata[SIZE_W-1:0];
                REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_BASE:  prdata = base_reg;
            REG_SIZE:  prdata = {{(APB_DW-SIZE_W){1'b0}}, size_reg};
            REG_COUNT: prdata = {{(APB_DW-COUNT_W){1'b0}}, count_reg};
            default:   prdata = '0;
        endcase
    end

    fspa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fspa_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (base_reg),
        .slot_size    (size_reg),
        .refill       (refill),
        .refill_count (pwdata[COUNT_W-1:0]),
        .mode         (mode),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_address (slot_address),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

// ===== tb/sv/fixed_slot_pool_allocator_tb.sv =====
// self-checking testbench for fixed_slot_pool_allocator: directed and random
// allocate/free traffic checked against a behavioural pool predictor
// depends on fspa_pkg and the fixed_slot_pool_allocator rtl
`timescale 1ns / 100ps

module fixed_slot_pool_allocator_tb;

    import fspa_pkg::*;

    localparam int POOL_DEPTH  = MAX_SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic              req_mode;
        logic [ADDR_W-1:0] req_addr;
    } pool_request_t;

    typedef struct {
        status_t           st;
        logic [ADDR_W-1:0] slot;
    } slot_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              mode = MODE_ALLOC;
    logic [ADDR_W-1:0] address = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        status;
    logic [ADDR_W-1:0] slot_address;

    // predictor copy of the configuration and free list
    logic [ADDR_W-1:0]  pool_base;
    logic [SIZE_W-1:0]  pool_size;
    logic [COUNT_W-1:0] pool_count;
    logic [9:0]         free_ring_copy [0:POOL_DEPTH-1];
    logic [9:0]         ring_head;
    logic [10:0]        free_total;

    pool_request_t pending_requests [$];
    slot_result_t  expected_results [$];
    int            fail_count = 0;
    int            results_seen = 0;
    int            cycle_count = 0;

    fixed_slot_pool_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_address (slot_address)
    );

    always #5 clk = ~clk;

    // slot size of zero behaves as one
    function automatic logic [31:0] eff_slot_size();
        return (pool_size == 0) ? 32'd1 : 32'(pool_size);
    endfunction

    // slot count is capped at the ring depth
    function automatic logic [31:0] eff_slot_count();
        return (pool_count > POOL_DEPTH) ? 32'(POOL_DEPTH) : 32'(pool_count);
    endfunction

    function automatic void refill_free_ring();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            free_ring_copy[i] = 10'(i);
        end
        ring_head  = '0;
        free_total = 11'(eff_slot_count());
    endfunction

    // expected result of one request, updating the free list copy
    function automatic slot_result_t pool_predict(input logic req_mode,
                                                  input logic [ADDR_W-1:0] req_addr);
        slot_result_t r;
        logic [31:0] sz;
        logic [31:0] cnt;
        logic [31:0] diff;
        logic [31:0] idx;
        sz     = eff_slot_size();
        cnt    = eff_slot_count();
        r.st   = ST_OK;
        r.slot = '0;
        if (req_mode == MODE_ALLOC)
        begin
            if (free_total == 0)
            begin
                r.st = ST_EMPTY;
            end
            else
            begin
                idx        = 32'(free_ring_copy[ring_head]);
                ring_head  = ring_head + 10'd1;
                free_total = free_total - 11'd1;
                r.slot     = pool_base + idx * sz;
            end
        end
        else if (req_addr == 0)
        begin
            r.st = ST_NULL;
        end
        else if (req_addr < pool_base)
        begin
            r.st = ST_RANGE;
        end
        else
        begin
            diff = req_addr - pool_base;
            idx  = diff / sz;
            if (diff % sz != 0)
            begin
                r.st = ST_MISALIGN;
            end
            else if (idx >= cnt)
            begin
                r.st = ST_RANGE;
            end
            else if (free_total >= cnt)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                free_ring_copy[10'(ring_head + free_total)] = idx[9:0];
                free_total = free_total + 11'd1;
            end
        end
        return r;
    endfunction

    task automatic queue_request(input logic req_mode, input logic [ADDR_W-1:0] req_addr);
        pool_request_t req;
        req.req_mode = req_mode;
        req.req_addr = req_addr;
        pending_requests.push_back(req);
    endtask

    // mostly legal frees and allocates, with a share of bad addresses
    task automatic queue_random_requests(input int n);
        logic [31:0] sz;
        logic [31:0] cnt;
        logic [31:0] slot_addr;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            sz        = eff_slot_size();
            cnt       = eff_slot_count();
            slot_addr = pool_base + ((cnt == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(0, cnt - 1)) * sz;
            pick      = $urandom_range(0, 99);
            if (pick < 42)
                queue_request(MODE_ALLOC, $urandom);
            else if (pick < 77)
                queue_request(MODE_FREE, slot_addr);
            else if (pick < 82)
                queue_request(MODE_FREE, '0);
            else if (pick < 89)
                queue_request(MODE_FREE,
                              slot_addr + ((sz > 1) ? $urandom_range(1, sz - 1) : 0));
            else if (pick < 94)
                queue_request(MODE_FREE,
                              (pool_base == 0) ? $urandom : $urandom_range(0, pool_base - 1));
            else if (pick < 97)
                queue_request(MODE_FREE, pool_base + (cnt + $urandom_range(0, 7)) * sz);
            else
                queue_request(MODE_FREE, $urandom);
        end
    endtask

    // wait until every request has been transferred and answered
    task automatic wait_for_drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // apb write: setup then access phase, predictor updated afterwards
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE:  pool_base = value;
            REG_SIZE:  pool_size = value[SIZE_W-1:0];
            REG_COUNT:
            begin
                pool_count = value[COUNT_W-1:0];
                refill_free_ring();
            end
            default: ;
        endcase
    endtask

    task automatic configure_pool(input logic [31:0] base, input logic [31:0] size,
                                  input logic [31:0] count);
        wait_for_drain();
        write_register(REG_BASE, base);
        write_register(REG_SIZE, size);
        write_register(REG_COUNT, count);
    endtask

    // request driver: bursts of transfers separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin : request_driver
        pool_request_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(pool_predict(mode, address));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    req      = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    mode     <= req.req_mode;
                    address  <= req.req_addr;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left   = $urandom_range(0, 12);
                        burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: stall pattern in stretches, plus long hold-offs
    int hold_left = 0;
    int hold_idx = 0;
    int stretch_left = 0;
    int stall_style = 0;
    int hold_marks [2] = '{205, 805};

    always @(posedge clk)
    begin : result_receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_idx < 2 && results_seen >= hold_marks[hold_idx])
        begin
            hold_left = HOLD_CYCLES;
            hold_idx++;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stall_style  = $urandom_range(0, 2);
                stretch_left = $urandom_range(20, 200);
            end
            else
            begin
                stretch_left--;
            end
            case (stall_style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result monitor: compare each transfer with the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        slot_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d slot_address 0x%08h",
                       status, slot_address);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (slot_address !== want.slot)
                begin
                    $error("slot_address: expected 0x%08h, got 0x%08h",
                           want.slot, slot_address);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        pool_base  = BASE_RESET;
        pool_size  = SIZE_RESET;
        pool_count = COUNT_RESET;
        refill_free_ring();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: empty pool
        queue_request(MODE_ALLOC, 32'hFFFF_FFFF);
        queue_request(MODE_FREE, 32'h0000_0000);
        queue_request(MODE_FREE, 32'h0000_0008);
        queue_request(MODE_FREE, 32'h0000_0003);
        queue_request(MODE_FREE, 32'hFFFF_FFFF);

        // small pool: exhaustion, bad frees, double free, full list
        configure_pool(32'h0000_1000, 32'd16, 32'd4);
        repeat (5) queue_request(MODE_ALLOC, 32'h0);
        queue_request(MODE_FREE, 32'h0000_0FF0);
        queue_request(MODE_FREE, 32'h0000_1008);
        queue_request(MODE_FREE, 32'h0000_1040);
        queue_request(MODE_FREE, 32'h0000_1010);
        queue_request(MODE_FREE, 32'h0000_1010);
        queue_request(MODE_FREE, 32'h0000_1000);
        queue_request(MODE_FREE, 32'h0000_1020);
        queue_request(MODE_FREE, 32'h0000_1030);
        repeat (2) queue_request(MODE_ALLOC, 32'h0);

        // oversized count, large slots, address wrap
        configure_pool(32'hFFFF_FFF0, 32'd4096, 32'd2047);
        repeat (2) queue_request(MODE_ALLOC, 32'h0);
        queue_request(MODE_FREE, 32'hFFFF_FFFF);
        queue_request(MODE_FREE, 32'hFFFF_FFF0);

        // random phases over a spread of settings
        configure_pool(32'h0, 32'd1, 32'd1);
        queue_random_requests(150);
        configure_pool($urandom, 32'd0, 32'd1024);
        queue_random_requests(150);
        configure_pool(32'hFFFF_F000, 32'd4096, 32'd1024);
        queue_random_requests(150);
        configure_pool($urandom_range(1, 32'h0001_0000), $urandom_range(1, 64),
                       $urandom_range(1, 16));
        queue_random_requests(150);
        configure_pool(32'hFFFF_FFFF, $urandom_range(1, 4096), 32'd0);
        queue_random_requests(150);
        configure_pool($urandom, $urandom_range(1, 4096), 32'd2047);
        queue_random_requests(150);
        configure_pool($urandom, $urandom_range(1, 4096), $urandom_range(2, 1024));
        queue_random_requests(150);

        wait_for_drain();
        repeat (50) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
